// File: hdl/lekb_pkg.sv
// shared constants and types for the line-edit keyboard buffer
`timescale 1ns / 1ps

package lekb_pkg;

   localparam int DEFAULT_BUFFER_DEPTH = 2048;

   localparam int CHAR_W   = 8;
   localparam int LENGTH_W = 6;
   localparam int KIND_W   = 2;

   localparam logic [CHAR_W-1:0] KEY_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] KEY_NEWLINE   = 8'd10;

   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_ECHO    = 2'd0,
      KIND_READ    = 2'd1,
      KIND_PENDING = 2'd2,
      KIND_EMPTY   = 2'd3
   } kind_type;

endpackage

// File: hdl/line_edit_keyboard_buffer.sv
// line-edit keyboard ring buffer with one pending reader
//
//  channel | dir | tdata (low bit up)                      | tuser  | tlast
//  req     | in  | key_char[7:0], read_length[13:8], 0 pad | opcode | -
//  rsp     | out | kind[1:0], out_char[9:2], count[15:10]  | -      | last
//
// a key passes through idle, backspace (backspace keys only) and check, and a drain
// visits a read state and an output state per delivered character (registered store read port)
// one input transaction is worked at a time; req_tready is high only when idle
// rsp stalls hold the sequencer in place, nothing is dropped
// reset clears pointers and counters at once; the character store is not cleared
`timescale 1ns / 1ps

module line_edit_keyboard_buffer #(
   parameter int BUFFER_DEPTH = lekb_pkg::DEFAULT_BUFFER_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // key_char, read_length, zero pad
   input  logic        req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // kind, out_char, count
   output logic        rsp_tlast    // last
);

   localparam int PW   = $clog2(BUFFER_DEPTH);
   localparam int CMPW = (PW > lekb_pkg::LENGTH_W) ? PW : lekb_pkg::LENGTH_W;
   localparam logic [PW-1:0] LAST_POS = PW'(BUFFER_DEPTH - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_BACKSPACE,
      S_CHECK,
      S_REQUEST,
      S_DRAIN_RD,
      S_DRAIN_OUT
   } state_type;

   typedef logic [lekb_pkg::CHAR_W-1:0]   char_type;
   typedef logic [lekb_pkg::LENGTH_W-1:0] len_type;

   function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
      return (p == LAST_POS) ? '0 : p + PW'(1);
   endfunction

   function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] p);
      return (p == '0) ? LAST_POS : p - PW'(1);
   endfunction

   state_type state_ff, state_in;
   logic [PW-1:0] wr_pos_ff, wr_pos_in;
   logic [PW-1:0] rd_pos_ff, rd_pos_in;
   logic [PW-1:0] unread_ff, unread_in;
   logic [PW-1:0] newlines_ff, newlines_in;
   len_type       pending_ff, pending_in;
   len_type       want_ff, want_in;
   len_type       cnt_ff, cnt_in;
   logic          echo_ff, echo_in;
   char_type      key_ff, key_in;
   len_type       len_ff, len_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_data_ff, rsp_data_in;
   logic          rsp_last_ff, rsp_last_in;

   // character store, one write and one registered read port
   char_type      store_mem [BUFFER_DEPTH];
   char_type      store_q_ff;
   logic          mem_we;
   logic [PW-1:0] mem_raddr;

   logic          req_fire;
   logic          out_free;
   logic          emit;
   lekb_pkg::kind_type emit_kind;
   char_type      emit_char;
   len_type       emit_count;
   logic          emit_last;
   logic          drain_go;
   logic          stop;
   len_type       cnt_next;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign mem_we    = req_fire && (req_tuser == lekb_pkg::OP_KEY)
                      && (req_tdata[7:0] != lekb_pkg::KEY_BACKSPACE)
                      && (ring_next(wr_pos_ff) != rd_pos_ff);
   // idle reads the newest character for a backspace, drain reads the oldest
   assign mem_raddr = (state_ff == S_DRAIN_RD || state_ff == S_DRAIN_OUT)
                      ? rd_pos_ff : ring_prev(wr_pos_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[wr_pos_ff] <= req_tdata[7:0];
      end
      store_q_ff <= store_mem[mem_raddr];
   end

   assign drain_go = (pending_ff != '0)
                     && ((CMPW'(unread_ff) >= CMPW'(pending_ff)) || (newlines_ff != '0));
   assign cnt_next = cnt_ff + len_type'(1);
   assign stop     = (store_q_ff == lekb_pkg::KEY_NEWLINE) || (cnt_next == want_ff)
                     || (unread_ff == PW'(1));

   always_comb begin
      state_in    = state_ff;
      wr_pos_in   = wr_pos_ff;
      rd_pos_in   = rd_pos_ff;
      unread_in   = unread_ff;
      newlines_in = newlines_ff;
      pending_in  = pending_ff;
      want_in     = want_ff;
      cnt_in      = cnt_ff;
      echo_in     = echo_ff;
      key_in      = key_ff;
      len_in      = len_ff;
      emit        = 1'b0;
      emit_kind   = lekb_pkg::KIND_EMPTY;
      emit_char   = '0;
      emit_count  = '0;
      emit_last   = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               key_in = req_tdata[7:0];
               len_in = req_tdata[13:8];
               echo_in = 1'b0;
               if (req_tuser == lekb_pkg::OP_READ) begin
                  state_in = S_REQUEST;
               end else if (req_tdata[7:0] == lekb_pkg::KEY_BACKSPACE) begin
                  state_in = S_BACKSPACE;
               end else begin
                  if (mem_we) begin
                     wr_pos_in = ring_next(wr_pos_ff);
                     unread_in = unread_ff + PW'(1);
                     if (req_tdata[7:0] == lekb_pkg::KEY_NEWLINE) begin
                        newlines_in = newlines_ff + PW'(1);
                     end
                     echo_in = (pending_ff != '0);
                  end
                  state_in = S_CHECK;
               end
            end
         end
         S_BACKSPACE: begin
            // store_q_ff holds the newest unread character here
            if (unread_ff != '0 && store_q_ff != lekb_pkg::KEY_NEWLINE) begin
               unread_in = unread_ff - PW'(1);
               wr_pos_in = ring_prev(wr_pos_ff);
               echo_in   = (pending_ff != '0);
            end
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!echo_ff || out_free) begin
               if (echo_ff) begin
                  emit      = 1'b1;
                  emit_kind = lekb_pkg::KIND_ECHO;
                  emit_char = key_ff;
                  emit_last = !drain_go;
                  echo_in   = 1'b0;
               end
               if (drain_go) begin
                  want_in    = pending_ff;
                  pending_in = '0;
                  cnt_in     = '0;
                  state_in   = S_DRAIN_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_REQUEST: begin
            if (len_ff == '0) begin
               if (out_free) begin
                  emit      = 1'b1;
                  emit_kind = lekb_pkg::KIND_EMPTY;
                  state_in  = S_IDLE;
               end
            end else if (CMPW'(unread_ff) < CMPW'(len_ff) && newlines_ff == '0) begin
               if (out_free) begin
                  emit       = 1'b1;
                  emit_kind  = lekb_pkg::KIND_PENDING;
                  pending_in = len_ff;
                  state_in   = S_IDLE;
               end
            end else begin
               pending_in = '0;
               want_in    = len_ff;
               cnt_in     = '0;
               state_in   = S_DRAIN_RD;
            end
         end
         S_DRAIN_RD: begin
            if (unread_ff == '0) begin
               if (out_free) begin
                  emit      = 1'b1;
                  emit_kind = lekb_pkg::KIND_EMPTY;
                  state_in  = S_IDLE;
               end
            end else begin
               state_in = S_DRAIN_OUT;
            end
         end
         S_DRAIN_OUT: begin
            if (out_free) begin
               emit       = 1'b1;
               emit_kind  = lekb_pkg::KIND_READ;
               emit_char  = store_q_ff;
               emit_count = cnt_next;
               emit_last  = stop;
               rd_pos_in  = ring_next(rd_pos_ff);
               unread_in  = unread_ff - PW'(1);
               if (store_q_ff == lekb_pkg::KEY_NEWLINE && newlines_ff != '0) begin
                  newlines_in = newlines_ff - PW'(1);
               end
               cnt_in   = cnt_next;
               state_in = stop ? S_IDLE : S_DRAIN_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {emit_count, emit_char, emit_kind};
         rsp_last_in  = emit_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wr_pos_ff    <= '0;
         rd_pos_ff    <= '0;
         unread_ff    <= '0;
         newlines_ff  <= '0;
         pending_ff   <= '0;
         echo_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_pos_ff    <= wr_pos_in;
         rd_pos_ff    <= rd_pos_in;
         unread_ff    <= unread_in;
         newlines_ff  <= newlines_in;
         pending_ff   <= pending_in;
         echo_ff      <= echo_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      want_ff     <= want_in;
      cnt_ff      <= cnt_in;
      key_ff      <= key_in;
      len_ff      <= len_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

// File: dv/tb_line_edit_keyboard_buffer.sv
// self-checking testbench for the line-edit keyboard ring buffer
`timescale 1ns / 1ps

module tb_line_edit_keyboard_buffer;

   localparam int DEPTH = lekb_pkg::DEFAULT_BUFFER_DEPTH;

   typedef struct {
      logic             op;
      logic [7:0]       ch;
      logic [5:0]       len;
   } line_req_type;

   typedef struct {
      lekb_pkg::kind_type kind;
      logic [7:0]       out_char;
      logic [5:0]       count;
      logic             last;
   } line_rsp_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = 16'h0000;   // key_char, read_length, zero pad
   logic        req_tuser  = 1'b0;       // opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;               // kind, out_char, count
   logic        rsp_tlast;               // last

   line_edit_keyboard_buffer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // shadow copy of the line buffer
   logic [7:0] shadow_ring [DEPTH];
   int         wr_ptr      = 0;
   int         rd_ptr      = 0;
   int         unread      = 0;
   int         newlines    = 0;
   int         waiting_len = 0;

   line_req_type  line_reqs [$];
   line_rsp_type  expected_rsp [$];
   line_rsp_type  step_rsps [$];
   line_rsp_type  want_rsp;
   line_req_type  next_req;

   int         errors   = 0;
   int         cycle_no = 0;
   int         req_gap  = 0;
   int         rsp_stall = 0;
   bit         req_done = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // mostly short gaps, a few long, and calm stretches with none
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (((cycle_no / 256) % 4) == 0) return 0;
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // hand out characters up to want or through the first newline
   function automatic void drain_line(int want);
      int         n;
      logic [7:0] c;
      n = 0;
      while (n < want && unread != 0) begin
         c = shadow_ring[rd_ptr];
         rd_ptr = (rd_ptr + 1) % DEPTH;
         unread--;
         n++;
         step_rsps.push_back('{lekb_pkg::KIND_READ, c, 6'(n), 1'b0});
         if (c == lekb_pkg::KEY_NEWLINE) begin
            if (newlines != 0) newlines--;
            break;
         end
      end
      if (n == 0) step_rsps.push_back('{lekb_pkg::KIND_EMPTY, 8'h00, 6'd0, 1'b0});
   endfunction

   function automatic void predict_line_edit(line_req_type r);
      int           want;
      line_rsp_type tail;
      step_rsps.delete();
      if (r.op == lekb_pkg::OP_KEY) begin
         if (r.ch == lekb_pkg::KEY_BACKSPACE) begin
            if (unread != 0 &&
                shadow_ring[(wr_ptr + DEPTH - 1) % DEPTH] != lekb_pkg::KEY_NEWLINE) begin
               unread--;
               wr_ptr = (wr_ptr + DEPTH - 1) % DEPTH;
               if (waiting_len != 0)
                  step_rsps.push_back('{lekb_pkg::KIND_ECHO, r.ch, 6'd0, 1'b0});
            end
         end else if ((wr_ptr + 1) % DEPTH != rd_ptr) begin
            shadow_ring[wr_ptr] = r.ch;
            wr_ptr = (wr_ptr + 1) % DEPTH;
            unread++;
            if (r.ch == lekb_pkg::KEY_NEWLINE) newlines++;
            if (waiting_len != 0)
               step_rsps.push_back('{lekb_pkg::KIND_ECHO, r.ch, 6'd0, 1'b0});
         end
         if (waiting_len != 0 && (unread >= waiting_len || newlines != 0)) begin
            want = waiting_len;
            waiting_len = 0;
            drain_line(want);
         end
      end else begin
         if (r.len == 0) begin
            step_rsps.push_back('{lekb_pkg::KIND_EMPTY, 8'h00, 6'd0, 1'b0});
         end else if (unread < int'(r.len) && newlines == 0) begin
            waiting_len = int'(r.len);
            step_rsps.push_back('{lekb_pkg::KIND_PENDING, 8'h00, 6'd0, 1'b0});
         end else begin
            waiting_len = 0;
            drain_line(int'(r.len));
         end
      end
      if (step_rsps.size() != 0) begin
         tail = step_rsps.pop_back();
         tail.last = 1'b1;
         step_rsps.push_back(tail);
      end
      foreach (step_rsps[i]) expected_rsp.push_back(step_rsps[i]);
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_done) begin
         // transaction still waiting for ready
      end else if (req_gap != 0) begin
         req_gap--;
         req_tvalid <= 1'b0;
      end else if (line_reqs.size() != 0) begin
         next_req = line_reqs.pop_front();
         req_tuser  <= next_req.op;
         req_tdata  <= {2'b00, next_req.len, next_req.ch};
         req_tvalid <= 1'b1;
         req_gap = pick_gap();
      end else begin
         req_tvalid <= 1'b0;
      end
      req_done = 1'b0;
   end

   // response backpressure
   always @(negedge clock) begin
      if (rsp_stall != 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         rsp_stall = pick_gap();
      end
   end

   // monitor: predict on request acceptance, check each response transaction
   always @(posedge clock) begin
      cycle_no++;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_line_edit('{req_tuser, req_tdata[7:0], req_tdata[13:8]});
            req_done = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp.size() == 0) begin
               $error("unexpected response transaction: tdata %h tlast %b",
                      rsp_tdata, rsp_tlast);
               errors++;
            end else begin
               want_rsp = expected_rsp.pop_front();
               if (rsp_tdata[1:0] !== want_rsp.kind) begin
                  $error("kind: expected %0d, actual %0d", want_rsp.kind, rsp_tdata[1:0]);
                  errors++;
               end
               if (rsp_tdata[9:2] !== want_rsp.out_char) begin
                  $error("out_char: expected %h, actual %h",
                         want_rsp.out_char, rsp_tdata[9:2]);
                  errors++;
               end
               if (rsp_tdata[15:10] !== want_rsp.count) begin
                  $error("count: expected %0d, actual %0d", want_rsp.count, rsp_tdata[15:10]);
                  errors++;
               end
               if (rsp_tlast !== want_rsp.last) begin
                  $error("last: expected %b, actual %b", want_rsp.last, rsp_tlast);
                  errors++;
               end
            end
         end
      end
   end

   function automatic void add_key(logic [7:0] ch);
      line_reqs.push_back('{lekb_pkg::OP_KEY, ch, 6'($urandom_range(0, 63))});
   endfunction

   function automatic void add_read(logic [5:0] len);
      line_reqs.push_back('{lekb_pkg::OP_READ, 8'($urandom_range(0, 255)), len});
   endfunction

   function automatic logic [5:0] pick_read_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return 6'd0;
      if (roll < 75) return 6'($urandom_range(1, 8));
      if (roll < 90) return 6'($urandom_range(9, 30));
      return 6'($urandom_range(31, 63));
   endfunction

   task automatic wait_idle();
      while (line_reqs.size() != 0 || req_tvalid || expected_rsp.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      int start_size;
      int line_len;
      int roll;
      int rand_items;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed
      add_read(6'd0);            // empty read
      add_key(lekb_pkg::KEY_BACKSPACE);    // nothing to delete
      add_read(6'd3);            // goes pending
      add_key(8'h61);
      add_key(lekb_pkg::KEY_BACKSPACE);    // deletion is echoed
      add_key(8'h00);
      add_key(8'hff);
      add_key(8'h62);            // third char serves the pending read
      add_read(6'd5);
      add_read(6'd2);            // replaces the pending read
      add_key(8'h78);
      add_key(lekb_pkg::KEY_NEWLINE);      // newline is the second char and serves it
      add_key(8'h68);
      add_key(8'h69);
      add_key(lekb_pkg::KEY_NEWLINE);
      add_key(lekb_pkg::KEY_BACKSPACE);    // newline is not erasable
      add_read(6'd63);           // stops at the newline
      add_read(6'd5);
      add_key(8'h6d);
      add_read(6'd1);            // replacement served at once
      add_key(8'h71);
      add_read(6'd63);
      add_key(lekb_pkg::KEY_NEWLINE);
      wait_idle();

      // random lines with edits, plus noise
      rand_items = 0;
      while (rand_items < 145) begin
         start_size = line_reqs.size();
         roll = $urandom_range(0, 99);
         if (roll < 70) begin
            line_len = $urandom_range(0, 10);
            repeat (line_len) begin
               if ($urandom_range(0, 5) == 0) add_key(lekb_pkg::KEY_BACKSPACE);
               else add_key(8'($urandom_range(32, 126)));
            end
            if ($urandom_range(0, 3) != 0) add_key(lekb_pkg::KEY_NEWLINE);
            add_read(pick_read_len());
         end else if (roll < 85) begin
            add_key(8'($urandom));
         end else begin
            add_read(6'($urandom));
         end
         rand_items += line_reqs.size() - start_size;
      end
      wait_idle();

      // empty what is left
      if (waiting_len != 0) begin
         add_key(lekb_pkg::KEY_NEWLINE);
         wait_idle();
      end
      while (unread != 0) begin
         add_read((unread < 63 && newlines == 0) ? 6'(unread) : 6'd63);
         wait_idle();
      end
      add_read(6'd63);           // nothing unread, no newline: must wait
      add_key(lekb_pkg::KEY_NEWLINE);
      wait_idle();

      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("tb_line_edit_keyboard_buffer passed");
      end else begin
         $display("tb_line_edit_keyboard_buffer failed");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("tb_line_edit_keyboard_buffer failed");
      $finish;
   end

endmodule
